[hw/rtl/button_debounce_long_press_assert.svh]
// Assertion macros for the button debouncer checker.
// Both macros sample on aclk and are disabled while aresetn is low.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Same-cycle implication.
`define BDLP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bdlp_pkg.sv]
package bdlp_pkg;

    // Number of buttons served (1 to 8).
    localparam int NUM_BUTTONS = 3;

    // Fixed field widths.
    localparam int ACT_W   = 2;
    localparam int PINS_W  = 3;
    localparam int IDX_W   = 3;
    localparam int FLAG_W  = 3;
    localparam int CNT_W   = 16;
    localparam int TDATA_W = 8;
    localparam int IDX_N   = 2 ** IDX_W;

    // APB
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_PRESSED_LEVEL = 2'd0;
    localparam logic [1:0] REG_LONG_TICKS    = 2'd1;
    localparam logic [1:0] REG_REPEAT_TICKS  = 2'd2;

    // Register reset values
    localparam logic             PRESSED_LEVEL_RST = 1'b0;
    localparam logic [CNT_W-1:0] LONG_TICKS_RST    = 16'd300;
    localparam logic [CNT_W-1:0] REPEAT_TICKS_RST  = 16'd100;

    // Item action codes; code 3 is unused: it changes no button and answers zero.
    typedef enum logic [ACT_W-1:0] {
        ACT_TICK       = 2'd0,
        ACT_READ_PRESS = 2'd1,
        ACT_READ_LONG  = 2'd2
    } act_t;

    typedef struct packed {
        logic             pressed_level;
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] repeat_ticks;
    } cfg_t;

    // Per-button control, already qualified by the input handshake.
    typedef struct packed {
        logic tick;
        logic level;
        logic clr_press;
        logic clr_long;
    } lane_ctrl_t;

    typedef struct packed {
        logic press_pend;
        logic long_pend;
    } lane_stat_t;

endpackage

[hw/rtl/bdlp_lane.sv]
module bdlp_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bdlp_pkg::cfg_t         cfg,
    input  bdlp_pkg::lane_ctrl_t   ctrl,
    output bdlp_pkg::lane_stat_t   stat_cur,
    output bdlp_pkg::lane_stat_t   stat_nxt
);
    import bdlp_pkg::*;

    // Released level after reset.
    localparam logic REL_RST = ~PRESSED_LEVEL_RST;

    // Only the two most recent samples are kept; both must match the new level.
    logic             samp0_reg,  samp0_next;
    logic             samp1_reg,  samp1_next;
    logic             stable_reg, stable_next;
    logic             repeat_reg, repeat_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             press_reg,  press_next;
    logic             longp_reg,  longp_next;

    logic             agree;
    logic             is_press;
    logic [CNT_W-1:0] count_dec;

    assign agree     = (samp0_reg == ctrl.level) && (samp1_reg == ctrl.level);
    assign is_press  = (ctrl.level == cfg.pressed_level);
    assign count_dec = (count_reg == '0) ? '0 : count_reg - CNT_W'(1);

    always_comb begin
        samp0_next  = samp0_reg;
        samp1_next  = samp1_reg;
        stable_next = stable_reg;
        repeat_next = repeat_reg;
        count_next  = count_reg;
        press_next  = press_reg;
        longp_next  = longp_reg;

        if (ctrl.tick) begin
            samp1_next = samp0_reg;
            samp0_next = ctrl.level;
            if (agree) begin
                if (stable_reg != ctrl.level) begin
                    stable_next = ctrl.level;
                    if (is_press) begin
                        if (!repeat_reg) begin
                            press_next = 1'b1;
                            count_next = cfg.long_press_ticks;
                        end else begin
                            count_next = cfg.repeat_ticks;
                        end
                    end else begin
                        repeat_next = 1'b0;
                    end
                end else begin
                    count_next = count_dec;
                    // hold expired: fire and force a release so it re-arms
                    if ((count_dec == '0) && is_press) begin
                        longp_next  = 1'b1;
                        stable_next = ~cfg.pressed_level;
                        repeat_next = 1'b1;
                    end
                end
            end
        end

        if (ctrl.clr_press) begin
            press_next = 1'b0;
        end
        if (ctrl.clr_long) begin
            longp_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samp0_reg  <= REL_RST;
            samp1_reg  <= REL_RST;
            stable_reg <= REL_RST;
            repeat_reg <= 1'b0;
            count_reg  <= '0;
            press_reg  <= 1'b0;
            longp_reg  <= 1'b0;
        end else begin
            samp0_reg  <= samp0_next;
            samp1_reg  <= samp1_next;
            stable_reg <= stable_next;
            repeat_reg <= repeat_next;
            count_reg  <= count_next;
            press_reg  <= press_next;
            longp_reg  <= longp_next;
        end
    end

    assign stat_cur.press_pend = press_reg;
    assign stat_cur.long_pend  = longp_reg;
    assign stat_nxt.press_pend = press_next;
    assign stat_nxt.long_pend  = longp_next;

endmodule

[hw/rtl/button_debounce_long_press.sv]
// Channel   Dir  Accept on            Payload
// --------  ---  -------------------  ----------------------------------------
// s_axis    in   tvalid & tready      action, pin_levels, button_index
// m_axis    out  tvalid & tready      answer, press_flags, long_flags
// apb       in   psel&penable&pwrite  pressed_level, long_press_ticks,
//                                     repeat_ticks
//
// One item per cycle unless m_axis stalls: every button updates in the cycle
// its item is accepted, and the result shows on m_axis in the next cycle.
// s_axis_tready is high while the result register is empty or being drained;
// a stalled result holds the input off until m_axis_tready rises.
// Reset (aresetn low, synchronous) returns all buttons to released and loads
// register defaults; no clearing pass is needed.
module button_debounce_long_press (
    input  logic                          aclk,
    input  logic                          aresetn,

    // tdata: [1:0] action, [4:2] pin_levels, [7:5] button_index
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bdlp_pkg::TDATA_W-1:0]  s_axis_tdata,

    // tdata: [0] answer, [3:1] press_flags, [6:4] long_flags, [7] zero
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bdlp_pkg::TDATA_W-1:0]  m_axis_tdata,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdlp_pkg::APB_AW-1:0]   paddr,
    input  logic [bdlp_pkg::APB_DW-1:0]   pwdata,
    output logic [bdlp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import bdlp_pkg::*;

    // ---------------- configuration registers ----------------
    logic             pressed_level_reg;
    logic [CNT_W-1:0] long_ticks_reg;
    logic [CNT_W-1:0] repeat_ticks_reg;
    logic             cfg_wr;
    logic [1:0]       cfg_sel;
    cfg_t             cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_level_reg <= PRESSED_LEVEL_RST;
            long_ticks_reg    <= LONG_TICKS_RST;
            repeat_ticks_reg  <= REPEAT_TICKS_RST;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_PRESSED_LEVEL: pressed_level_reg <= pwdata[0];
                REG_LONG_TICKS:    long_ticks_reg    <= pwdata[CNT_W-1:0];
                REG_REPEAT_TICKS:  repeat_ticks_reg  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_PRESSED_LEVEL: prdata = {{(APB_DW-1){1'b0}}, pressed_level_reg};
            REG_LONG_TICKS:    prdata = {{(APB_DW-CNT_W){1'b0}}, long_ticks_reg};
            REG_REPEAT_TICKS:  prdata = {{(APB_DW-CNT_W){1'b0}}, repeat_ticks_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.pressed_level    = pressed_level_reg;
    assign cfg.long_press_ticks = long_ticks_reg;
    assign cfg.repeat_ticks     = repeat_ticks_reg;

    // ---------------- input item decode ----------------
    logic              s_fire;
    act_t              action;
    logic [PINS_W-1:0] pins;
    logic [IDX_W-1:0]  idx;
    logic [IDX_N-1:0]  pins_pad;
    logic              idx_ok;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign action   = act_t'(s_axis_tdata[ACT_W-1:0]);
    assign pins     = s_axis_tdata[ACT_W +: PINS_W];
    assign idx      = s_axis_tdata[ACT_W+PINS_W +: IDX_W];
    // buttons beyond the pin field see a constant low level
    assign pins_pad = {{(IDX_N-PINS_W){1'b0}}, pins};
    assign idx_ok   = ({1'b0, idx} < (IDX_W+1)'(NUM_BUTTONS));

    // ---------------- per-button lanes ----------------
    lane_stat_t       stat_cur [NUM_BUTTONS];
    lane_stat_t       stat_nxt [NUM_BUTTONS];
    logic [IDX_N-1:0] press_cur, long_cur;
    logic [IDX_N-1:0] press_nxt, long_nxt;

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        lane_ctrl_t ctrl;

        assign ctrl.tick      = s_fire && (action == ACT_TICK);
        assign ctrl.level     = pins_pad[b];
        assign ctrl.clr_press = s_fire && (action == ACT_READ_PRESS) && (idx == IDX_W'(b));
        assign ctrl.clr_long  = s_fire && (action == ACT_READ_LONG) && (idx == IDX_W'(b));

        bdlp_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cfg      (cfg),
            .ctrl     (ctrl),
            .stat_cur (stat_cur[b]),
            .stat_nxt (stat_nxt[b])
        );
    end

    always_comb begin
        press_cur = '0;
        long_cur  = '0;
        press_nxt = '0;
        long_nxt  = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            press_cur[b] = stat_cur[b].press_pend;
            long_cur[b]  = stat_cur[b].long_pend;
            press_nxt[b] = stat_nxt[b].press_pend;
            long_nxt[b]  = stat_nxt[b].long_pend;
        end
    end

    // answer is the flag before the read clears it
    logic answer;

    always_comb begin
        case (action)
            ACT_READ_PRESS: answer = idx_ok && press_cur[idx];
            ACT_READ_LONG:  answer = idx_ok && long_cur[idx];
            default:        answer = 1'b0;
        endcase
    end

    // ---------------- result register ----------------
    logic               m_valid_reg;
    logic [TDATA_W-1:0] m_data_reg;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            m_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= {1'b0, long_nxt[FLAG_W-1:0], press_nxt[FLAG_W-1:0], answer};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

[hw/rtl/bdlp_checker.sv]
`include "button_debounce_long_press_assert.svh"

module bdlp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [bdlp_pkg::TDATA_W-1:0]  s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bdlp_pkg::TDATA_W-1:0]  m_axis_tdata
);
    import bdlp_pkg::*;

    logic s_fire;
    logic m_stall;
    logic tick_fire;
    logic rd_press_fire;

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_stall       = m_axis_tvalid && !m_axis_tready;
    assign tick_fire     = s_fire && (s_axis_tdata[1:0] == ACT_TICK);
    assign rd_press_fire = s_fire && (s_axis_tdata[1:0] == ACT_READ_PRESS);

    // every accepted item leaves a result behind it
    `BDLP_ASSERT_NEXT(a_item_gives_result, s_fire, m_axis_tvalid, "accepted item lost")

    // an empty output register never blocks the input
    `BDLP_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "stalled while empty")

    // a stalled result holds
    `BDLP_ASSERT_NEXT(a_hold_on_stall, m_stall,
        m_axis_tvalid && $stable(m_axis_tdata),
        "result changed while stalled")

    // ticks answer zero
    `BDLP_ASSERT_NEXT(a_tick_answer_zero, tick_fire, m_axis_tdata[0] == 1'b0,
        "tick answered nonzero")

    // a short-press read leaves that button's flag clear
    `BDLP_ASSERT_NEXT(a_read_clears, rd_press_fire,
        ((m_axis_tdata[3:1] >> $past(s_axis_tdata[7:5])) & 3'b001) == 3'b000,
        "press flag not cleared by read")

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (.*);
